### hdl/osc_pkg.sv
package osc_pkg;

    // Width of the buffer radius register and of its square.
    localparam int RADIUS_W = 15;
    localparam int RADIUS_SQ_W = 2 * RADIUS_W;

    // Start value of the setup wait counter, which counts down to zero.
    localparam logic [1:0] SETUP_LAST = 2'd3;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_SEGMENT = 2'd2,
        REQ_POINT   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_FULL = 2'd1,
        RES_HIT  = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SETUP  = 3'd1,
        ST_SCAN   = 3'd2,
        ST_DRAIN  = 3'd3,
        ST_RESULT = 3'd4
    } state_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      append;
        logic      issue;
        logic      res_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic zero_len;
        logic scan_done;
        logic busy;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/osc_ctrl.sv
module osc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  osc_pkg::dp_status_t status,
    output osc_pkg::dp_cmd_t    cmd
);

    osc_pkg::state_t    state_reg, state_next;
    osc_pkg::req_t      req_reg, req_next;
    osc_pkg::res_kind_t kind_reg, kind_next;
    logic [1:0]         wait_reg, wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= osc_pkg::ST_IDLE;
            req_reg   <= osc_pkg::REQ_CLEAR;
            kind_reg  <= osc_pkg::RES_NONE;
            wait_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            kind_reg  <= kind_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        kind_next    = kind_reg;
        wait_next    = wait_reg;
        in_stall     = 1'b1;
        cmd.load     = 1'b0;
        cmd.clear    = 1'b0;
        cmd.append   = 1'b0;
        cmd.issue    = 1'b0;
        cmd.res_load = 1'b0;
        cmd.res_kind = kind_reg;

        case (state_reg)
            osc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    req_next = osc_pkg::req_t'(req_type);
                    case (osc_pkg::req_t'(req_type))
                        osc_pkg::REQ_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            kind_next  = osc_pkg::RES_NONE;
                            state_next = osc_pkg::ST_RESULT;
                        end
                        osc_pkg::REQ_APPEND:
                        begin
                            // A full table drops the obstacle and flags it.
                            if (status.full)
                            begin
                                kind_next = osc_pkg::RES_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                kind_next  = osc_pkg::RES_NONE;
                            end
                            state_next = osc_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            kind_next  = osc_pkg::RES_HIT;
                            wait_next  = osc_pkg::SETUP_LAST;
                            state_next = osc_pkg::ST_SETUP;
                        end
                    endcase
                end
            end
            osc_pkg::ST_SETUP:
            begin
                if (status.count_zero ||
                    (req_reg == osc_pkg::REQ_SEGMENT && status.zero_len))
                begin
                    kind_next  = osc_pkg::RES_NONE;
                    state_next = osc_pkg::ST_RESULT;
                end
                else if (wait_reg == 2'd0)
                begin
                    state_next = osc_pkg::ST_SCAN;
                end
                else
                begin
                    wait_next = wait_reg - 2'd1;
                end
            end
            osc_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = osc_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            osc_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = osc_pkg::ST_RESULT;
                end
            end
            osc_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = osc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = osc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/osc_datapath.sv
module osc_datapath #(
    parameter int MAX_OBSTACLES = 256,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  osc_pkg::dp_cmd_t                     cmd,
    output osc_pkg::dp_status_t                  status,
    input  logic [1:0]                           req_type,
    input  logic signed [COORD_WIDTH-1:0]        first_x,
    input  logic signed [COORD_WIDTH-1:0]        first_y,
    input  logic signed [COORD_WIDTH-1:0]        second_x,
    input  logic signed [COORD_WIDTH-1:0]        second_y,
    input  logic                                 cfg_write,
    input  logic [osc_pkg::RADIUS_W-1:0]         cfg_data,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic                                 collision,
    output logic                                 table_full
);

    localparam int C    = COORD_WIDTH;
    localparam int IW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNTW = $clog2(MAX_OBSTACLES + 1);
    localparam int R2W  = osc_pkg::RADIUS_SQ_W;
    localparam int NW   = 2 * C + 2;
    localparam int H    = C + 1;
    localparam int LW   = 2 * C + 2;
    localparam int LL   = C + 1;
    localparam int NSQW = 4 * C + 4;
    localparam int RLW  = R2W + LW;
    localparam int CMPW = (NSQW > RLW) ? NSQW : RLW;
    localparam int PTW  = (2 * C + 2 > R2W) ? 2 * C + 2 : R2W;
    localparam int BW   = ((C > 16) ? C : 16) + 2;

    // Obstacle table, {y, x} per entry.
    logic [2*C-1:0] mem [MAX_OBSTACLES];

    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] idx_reg;
    logic [osc_pkg::RADIUS_W-1:0] radius_reg;
    logic [R2W-1:0] r2_reg;

    // Query registers and per-query setup terms.
    logic                qseg_reg;
    logic signed [C-1:0] qx1_reg, qy1_reg, qx2_reg, qy2_reg;
    logic signed [C:0]   dx_reg, dy_reg;
    logic signed [2*C-1:0] xa_reg, xb_reg;
    logic [LW-1:0]       dxsq_reg, dysq_reg, len2_reg;
    logic signed [2*C:0] cross_reg;
    logic [R2W+LL-1:0]   rl_reg;
    logic [R2W+LW-LL-1:0] rh_reg;
    logic [CMPW-1:0]     rlen_reg;

    logic signed [2*C-1:0] xa_next, xb_next;
    logic signed [2*C+1:0] dxsq_s, dysq_s;

    // Scan pipeline.
    logic                  s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [2*C-1:0]        rd_reg;
    logic signed [C-1:0]   ox, oy;
    logic signed [osc_pkg::RADIUS_W:0] rs;
    logic signed [BW-1:0]  xp, xm, yp, ym;
    logic                  box_next;
    logic signed [2*C:0]   p1_next, p2_next;
    logic signed [2*C:0]   p1_reg, p2_reg;
    logic signed [C:0]     dpx_reg, dpy_reg;
    logic                  box2_reg, box3_reg, box4_reg;
    logic signed [NW-1:0]  num, num_neg;
    logic [NW-1:0]         an_reg;
    logic signed [2*C+1:0] sqx_s, sqy_s;
    logic [2*C+1:0]        sqx_reg, sqy_reg;
    logic [2*H-1:0]        hh_reg, hl_reg, ll_reg;
    logic                  pt4_reg;
    logic [CMPW-1:0]       nsq;
    logic                  hit_reg;
    logic                  elem_hit;

    logic out_valid_reg, collision_reg, table_full_reg;

    // Table bookkeeping and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            radius_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                radius_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg[IW-1:0]] <= {first_y, first_x};
        end
        if (cmd.issue)
        begin
            rd_reg <= mem[idx_reg[IW-1:0]];
        end
    end

    // Query capture and setup terms; these settle during the setup state and
    // then hold for the rest of the query.
    assign xa_next = (2*C)'(qx2_reg) * (2*C)'(qy1_reg);
    assign xb_next = (2*C)'(qy2_reg) * (2*C)'(qx1_reg);
    assign dxsq_s  = (2*C+2)'(dx_reg) * (2*C+2)'(dx_reg);
    assign dysq_s  = (2*C+2)'(dy_reg) * (2*C+2)'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qseg_reg <= (osc_pkg::req_t'(req_type) == osc_pkg::REQ_SEGMENT);
            qx1_reg  <= first_x;
            qy1_reg  <= first_y;
            qx2_reg  <= second_x;
            qy2_reg  <= second_y;
            dx_reg   <= (C+1)'(second_x) - (C+1)'(first_x);
            dy_reg   <= (C+1)'(second_y) - (C+1)'(first_y);
        end
        r2_reg    <= R2W'(radius_reg) * R2W'(radius_reg);
        xa_reg    <= xa_next;
        xb_reg    <= xb_next;
        dxsq_reg  <= $unsigned(dxsq_s);
        dysq_reg  <= $unsigned(dysq_s);
        cross_reg <= (2*C+1)'(xa_reg) - (2*C+1)'(xb_reg);
        len2_reg  <= dxsq_reg + dysq_reg;
        rl_reg    <= (R2W+LL)'(r2_reg) * (R2W+LL)'(len2_reg[LL-1:0]);
        rh_reg    <= (R2W+LW-LL)'(r2_reg) * (R2W+LW-LL)'(len2_reg[LW-1:LL]);
        rlen_reg  <= CMPW'(rl_reg) + (CMPW'(rh_reg) << LL);
    end

    // Stage 2: box test, line products, point offsets.
    assign ox = rd_reg[C-1:0];
    assign oy = rd_reg[2*C-1:C];
    assign rs = $signed({1'b0, radius_reg});
    assign xp = BW'(ox) + BW'(rs);
    assign xm = BW'(ox) - BW'(rs);
    assign yp = BW'(oy) + BW'(rs);
    assign ym = BW'(oy) - BW'(rs);
    assign box_next = !(((xp <= BW'(qx2_reg)) && (xp <= BW'(qx1_reg))) ||
                        ((xm >= BW'(qx2_reg)) && (xm >= BW'(qx1_reg))) ||
                        ((yp <= BW'(qy2_reg)) && (yp <= BW'(qy1_reg))) ||
                        ((ym >= BW'(qy2_reg)) && (ym >= BW'(qy1_reg))));
    assign p1_next = (2*C+1)'(dy_reg) * (2*C+1)'(ox);
    assign p2_next = (2*C+1)'(dx_reg) * (2*C+1)'(oy);

    // Stage 3: signed distance numerator and point squares.
    assign num     = NW'(p1_reg) - NW'(p2_reg) + NW'(cross_reg);
    assign num_neg = -num;
    assign sqx_s   = (2*C+2)'(dpx_reg) * (2*C+2)'(dpx_reg);
    assign sqy_s   = (2*C+2)'(dpy_reg) * (2*C+2)'(dpy_reg);

    // Stage 4 feeds the final compare; the squared numerator is rebuilt
    // from its three partial products.
    assign nsq = (CMPW'(hh_reg) << (2 * H)) + (CMPW'(hl_reg) << (H + 1)) +
                 CMPW'(ll_reg);
    assign elem_hit = s4_v_reg &&
                      (qseg_reg ? (box4_reg && (nsq <= rlen_reg)) : pt4_reg);

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        dpx_reg  <= (C+1)'(ox) - (C+1)'(qx1_reg);
        dpy_reg  <= (C+1)'(oy) - (C+1)'(qy1_reg);
        box2_reg <= box_next;

        an_reg   <= num[NW-1] ? $unsigned(num_neg) : $unsigned(num);
        sqx_reg  <= $unsigned(sqx_s);
        sqy_reg  <= $unsigned(sqy_s);
        box3_reg <= box2_reg;

        hh_reg   <= (2*H)'(an_reg[NW-1:H]) * (2*H)'(an_reg[NW-1:H]);
        hl_reg   <= (2*H)'(an_reg[NW-1:H]) * (2*H)'(an_reg[H-1:0]);
        ll_reg   <= (2*H)'(an_reg[H-1:0]) * (2*H)'(an_reg[H-1:0]);
        pt4_reg  <= (PTW'(sqx_reg) + PTW'(sqy_reg)) < PTW'(r2_reg);
        box4_reg <= box3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (elem_hit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Output register: a finished beat waits here while the next request
    // is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                osc_pkg::RES_FULL:
                begin
                    collision_reg  <= 1'b0;
                    table_full_reg <= 1'b1;
                end
                osc_pkg::RES_HIT:
                begin
                    collision_reg  <= hit_reg;
                    table_full_reg <= 1'b0;
                end
                default:
                begin
                    collision_reg  <= 1'b0;
                    table_full_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign collision  = collision_reg;
    assign table_full = table_full_reg;

    assign status.full       = (count_reg == CNTW'(MAX_OBSTACLES));
    assign status.count_zero = (count_reg == '0);
    assign status.zero_len   = (dx_reg == '0) && (dy_reg == '0);
    assign status.scan_done  = (idx_reg == count_reg);
    assign status.busy       = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

endmodule

### hdl/obstacle_segment_collision_check.sv
// Obstacle table with segment and point collision queries.
// Input channel: in_valid/in_stall with req_type and two coordinate pairs.
// A beat is taken when in_valid is high and in_stall is low. Append
// uses only the first pair and clear uses neither; a segment query uses
// both; a point query uses the first. Every request gives exactly one
// output beat on out_valid/out_stall carrying collision and table_full.
// The buffer radius is written through cfg_write/cfg_data; the user must
// do so only while idle, which the block does not enforce. Clear and
// append go from acceptance to the result state, then to the output
// register. A query passes through setup, one table read per obstacle
// from the single memory read port, the pipeline drain and the result
// load. Requests are handled one at a time.
// Reset empties the table and zeroes the radius; table contents are
// undefined until written. A result held by out_stall stays in the output
// register while the next request is accepted and worked on; that request
// then waits for the register to free before it loads its own result.
module obstacle_segment_collision_check #(
    parameter int MAX_OBSTACLES = 256,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic                          cfg_write,
    input  logic [osc_pkg::RADIUS_W-1:0]  cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          collision,
    output logic                          table_full
);

    osc_pkg::dp_cmd_t    cmd;
    osc_pkg::dp_status_t status;

    osc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    osc_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_type   (req_type),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .collision  (collision),
        .table_full (table_full)
    );

endmodule

### hdl/osc_checker.sv
module osc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] req_type,
    input logic       out_valid,
    input logic       out_stall,
    input logic       collision,
    input logic       table_full
);

    // A held output beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(collision) && $stable(table_full))
    else $error("output beat changed while stalled");

    // Requests are worked one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

    // A beat never reports both a hit and a dropped append.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(collision && table_full))
    else $error("collision and table_full both set");

    // A clear with a free output register passes through the result state and then answers with zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == osc_pkg::REQ_CLEAR) && !out_valid
        |=> ##1 out_valid && !collision && !table_full)
    else $error("clear result missing or wrong");

endmodule

bind obstacle_segment_collision_check osc_checker u_osc_checker (.*);

### tb/obstacle_segment_collision_check_tb.sv
`timescale 1ns / 1ps

module obstacle_segment_collision_check_tb;

    localparam int TABLE_DEPTH  = 256;
    localparam int COORD_W      = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [osc_pkg::RADIUS_W-1:0] radius_t;

    localparam coord_t  COORD_MIN  = -32768;
    localparam coord_t  COORD_MAX  = 32767;
    localparam radius_t RADIUS_MAX = '1;

    typedef struct packed {
        logic collision;
        logic table_full;
    } outcome_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    class collision_tracker;
        coord_t      obs_x [TABLE_DEPTH];
        coord_t      obs_y [TABLE_DEPTH];
        int unsigned obs_count;
        radius_t     radius;
        outcome_t    pending_outcomes [$];
        int unsigned errors;
        int unsigned hits;
        int unsigned drops;
        int unsigned beats;
        int unsigned kind_count [4];

        function new();
            obs_count = 0;
            radius    = '0;
            errors    = 0;
            hits      = 0;
            drops     = 0;
            beats     = 0;
            foreach (kind_count[i])
                kind_count[i] = 0;
        endfunction

        function void set_radius(radius_t value);
            radius = value;
        endfunction

        // Exact squared test against the line through both endpoints, after the
        // box test widened by the radius. Products need more than 64 bits.
        function bit segment_hits(longint x1, longint y1, longint x2, longint y2);
            longint r;
            longint dx;
            longint dy;
            longint ox;
            longint oy;
            longint num;
            logic signed [127:0] num_w;
            logic signed [127:0] num_sq;
            logic signed [127:0] reach_sq;
            r  = longint'(radius);
            dx = x2 - x1;
            dy = y2 - y1;
            if (dx == 0 && dy == 0)
                return 1'b0;
            reach_sq = dx * dx + dy * dy;
            reach_sq = reach_sq * (r * r);
            for (int i = 0; i < obs_count; i++)
            begin
                ox = obs_x[i];
                oy = obs_y[i];
                if ((ox + r <= x1 && ox + r <= x2) || (ox - r >= x1 && ox - r >= x2))
                    continue;
                if ((oy + r <= y1 && oy + r <= y2) || (oy - r >= y1 && oy - r >= y2))
                    continue;
                num    = dy * ox - dx * oy + (x2 * y1 - y2 * x1);
                num_w  = num;
                num_sq = num_w * num_w;
                if (num_sq <= reach_sq)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit point_hits(longint px, longint py);
            longint r;
            longint ax;
            longint ay;
            r = longint'(radius);
            for (int i = 0; i < obs_count; i++)
            begin
                ax = longint'(obs_x[i]) - px;
                ay = longint'(obs_y[i]) - py;
                if (ax * ax + ay * ay < r * r)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(osc_pkg::req_t req, coord_t x1, coord_t y1,
                                   coord_t x2, coord_t y2);
            outcome_t res;
            res = '0;
            beats++;
            kind_count[req]++;
            case (req)
                osc_pkg::REQ_CLEAR:
                    obs_count = 0;
                osc_pkg::REQ_APPEND:
                    if (obs_count >= TABLE_DEPTH)
                        res.table_full = 1'b1;
                    else
                    begin
                        obs_x[obs_count] = x1;
                        obs_y[obs_count] = y1;
                        obs_count++;
                    end
                osc_pkg::REQ_SEGMENT:
                    res.collision = segment_hits(x1, y1, x2, y2);
                default:
                    res.collision = point_hits(x1, y1);
            endcase
            pending_outcomes = {pending_outcomes, res};
        endfunction

        function void check_result(logic collision, logic table_full);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: collision=%0b table_full=%0b",
                             collision, table_full);
                return;
            end
            want = pending_outcomes.pop_front();
            if (collision !== want.collision || table_full !== want.table_full)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: collision exp %0b got %0b, table_full exp %0b got %0b",
                             want.collision, collision, want.table_full, table_full);
            end
            else
            begin
                hits  += collision;
                drops += table_full;
            end
        endfunction

        function int unsigned pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_stall;
    logic [1:0] req_type = '0;
    coord_t  first_x    = '0;
    coord_t  first_y    = '0;
    coord_t  second_x   = '0;
    coord_t  second_y   = '0;
    logic    cfg_write  = 1'b0;
    radius_t cfg_data   = '0;
    logic    out_valid;
    logic    out_stall  = 1'b0;
    logic    collision;
    logic    table_full;

    collision_tracker tracker = new();

    int          burst_left    = 0;
    int          radius_writes = 0;
    stall_mode_t stall_mode    = STALL_NONE;
    int unsigned stall_left    = 0;
    int unsigned stall_tick    = 0;

    obstacle_segment_collision_check #(
        .MAX_OBSTACLES(TABLE_DEPTH),
        .COORD_WIDTH  (COORD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .collision (collision),
        .table_full(table_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver switches at random between four stall patterns.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(32, 400);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(collision, table_full);
    end

    function automatic coord_t near(int center, int spread);
        int v;
        v = center - spread + int'($urandom_range(0, 2 * spread));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'($urandom());
    endfunction

    // Must be called in the time step of a rising edge. Valid stays high
    // from one beat to the next inside a burst.
    task automatic send_req(osc_pkg::req_t req, coord_t x1, coord_t y1, coord_t x2,
                            coord_t y2);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= req;
        first_x  <= x1;
        first_y  <= y1;
        second_x <= x2;
        second_y <= y2;
        do @(posedge clk); while (in_stall);
        tracker.note_request(req, x1, y1, x2, y2);
    endtask

    task automatic send_noise();
        send_req(osc_pkg::req_t'($urandom_range(0, 3)), any_coord(), any_coord(),
                 any_coord(), any_coord());
    endtask

    // The radius only changes once every outstanding result has come back.
    task automatic set_radius_idle(radius_t value);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_radius(value);
        radius_writes++;
        burst_left = 0;
    endtask

    // One phase: a radius, usually a clear, a table of obstacles around one
    // spot, then queries near that spot with some noise mixed in.
    task automatic run_phase(bit fill);
        int      cx;
        int      cy;
        int      spread;
        int      n_obs;
        int      n_query;
        radius_t r;
        coord_t  ax;
        coord_t  ay;
        coord_t  bx;
        coord_t  by;
        cx     = int'($urandom_range(0, 65535)) - 32768;
        cy     = int'($urandom_range(0, 65535)) - 32768;
        spread = 1 << $urandom_range(2, 12);
        case ($urandom_range(0, 9))
            0:       r = '0;
            1:       r = RADIUS_MAX;
            2:       r = 1;
            3:       r = radius_t'($urandom());
            default: r = radius_t'($urandom_range(1, 2 * spread));
        endcase
        set_radius_idle(r);
        if (fill || $urandom_range(0, 5) != 0)
            send_req(osc_pkg::REQ_CLEAR, any_coord(), any_coord(), any_coord(),
                     any_coord());
        n_obs   = fill ? TABLE_DEPTH + $urandom_range(1, 4) : $urandom_range(0, 24);
        n_query = fill ? $urandom_range(4, 8) : $urandom_range(3, 18);
        for (int i = 0; i < n_obs; i++)
        begin
            if (!fill && $urandom_range(0, 11) == 0)
                send_noise();
            else if ($urandom_range(0, 9) == 0)
                send_req(osc_pkg::REQ_APPEND, any_coord(), any_coord(), any_coord(),
                         any_coord());
            else
                send_req(osc_pkg::REQ_APPEND, near(cx, spread), near(cy, spread),
                         any_coord(), any_coord());
        end
        for (int i = 0; i < n_query; i++)
        begin
            ax = near(cx, spread);
            ay = near(cy, spread);
            bx = near(cx, spread);
            by = near(cy, spread);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else if ($urandom_range(0, 1) == 0)
                send_req(osc_pkg::REQ_POINT, ax, ay, any_coord(), any_coord());
            else
            begin
                case ($urandom_range(0, 9))
                    0: send_req(osc_pkg::REQ_SEGMENT, ax, ay, ax, ay);
                    1: send_req(osc_pkg::REQ_SEGMENT, ax, ay, any_coord(), any_coord());
                    default: send_req(osc_pkg::REQ_SEGMENT, ax, ay, bx, by);
                endcase
            end
        end
    endtask

    initial
    begin
        int phase_no;
        int start_beats;
        phase_no = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Radius is zero out of reset: nothing is closer than zero, but a
        // segment straight through an obstacle still counts.
        send_req(osc_pkg::REQ_SEGMENT, -16, 0, 16, 0);
        send_req(osc_pkg::REQ_POINT, 0, 0, 0, 0);
        send_req(osc_pkg::REQ_APPEND, 0, 0, 0, 0);
        send_req(osc_pkg::REQ_POINT, 0, 0, 0, 0);
        send_req(osc_pkg::REQ_SEGMENT, -16, -16, 16, 16);

        set_radius_idle(RADIUS_MAX);
        send_req(osc_pkg::REQ_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_req(osc_pkg::REQ_POINT, COORD_MIN, COORD_MIN, 0, 0);
        send_req(osc_pkg::REQ_APPEND, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_req(osc_pkg::REQ_APPEND, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_req(osc_pkg::REQ_APPEND, COORD_MIN, COORD_MAX, 0, 0);
        send_req(osc_pkg::REQ_APPEND, COORD_MAX, COORD_MIN, 0, 0);
        send_req(osc_pkg::REQ_POINT, COORD_MAX, COORD_MAX, 0, 0);
        send_req(osc_pkg::REQ_POINT, 0, 0, COORD_MIN, COORD_MAX);
        send_req(osc_pkg::REQ_SEGMENT, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_req(osc_pkg::REQ_SEGMENT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_req(osc_pkg::REQ_SEGMENT, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);

        set_radius_idle(16);
        send_req(osc_pkg::REQ_SEGMENT, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
        send_req(osc_pkg::REQ_POINT, coord_t'(COORD_MIN + 15), COORD_MIN, 0, 0);
        send_req(osc_pkg::REQ_POINT, coord_t'(COORD_MIN + 16), COORD_MIN, 0, 0);
        send_req(osc_pkg::REQ_CLEAR, 0, 0, 0, 0);
        send_req(osc_pkg::REQ_SEGMENT, 0, 100, 200, 100);
        send_req(osc_pkg::REQ_APPEND, 100, 100, 0, 0);
        send_req(osc_pkg::REQ_SEGMENT, 0, 100, 200, 100);
        send_req(osc_pkg::REQ_SEGMENT, 100, 100, 100, 100);

        // Phase two always fills the table past its depth.
        start_beats = tracker.beats;
        while (tracker.beats < start_beats + RANDOM_ITEMS)
        begin
            run_phase(phase_no == 2 || $urandom_range(0, 39) == 0);
            phase_no++;
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d clear, %0d append, %0d segment, %0d point",
                 tracker.beats, tracker.kind_count[osc_pkg::REQ_CLEAR],
                 tracker.kind_count[osc_pkg::REQ_APPEND],
                 tracker.kind_count[osc_pkg::REQ_SEGMENT],
                 tracker.kind_count[osc_pkg::REQ_POINT]);
        $display("%0d radius settings, %0d collisions, %0d dropped appends, %0d mismatches",
                 radius_writes, tracker.hits, tracker.drops, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("obstacle_segment_collision_check_tb: done, clean");
        else
            $display("obstacle_segment_collision_check_tb: done, errors");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("obstacle_segment_collision_check_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
hdl/osc_pkg.sv
hdl/osc_ctrl.sv
hdl/osc_datapath.sv
hdl/obstacle_segment_collision_check.sv
hdl/osc_checker.sv
tb/obstacle_segment_collision_check_tb.sv
